@@ hw/rtl/nce_pkg.sv @@
// shared types, codes and constants of the nurbs curve point evaluator
// used by nce_div, nce_core and nurbs_curve_point_eval; no dependencies
package nce_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_KNOT  = 2'd0,
        OP_LOAD_POINT = 2'd1,
        OP_EVAL       = 2'd2,
        OP_NONE       = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_WEIGHT_REJ = 3'd1,
        STS_INDEX_REJ  = 3'd2,
        STS_BAD_CFG    = 3'd3,
        STS_DEGEN      = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE, S_LO, S_HI, S_SRCH, S_LRA, S_LRL, S_LRR, S_BAS, S_BMUL, S_BDIV,
        S_WA, S_WN, S_WX, S_WY, S_WZ, S_WE, S_FIN, S_DEG, S_DIV, S_DONE
    } state_t;

    // store sizes, tied to the 2-bit degree and 7-bit index fields
    localparam int MAX_DEGREE = 3;
    localparam int MAX_POINTS = 64;

    localparam logic [0:0] REG_DEGREE      = 1'd0;
    localparam logic [0:0] REG_POINT_COUNT = 1'd1;
    localparam int         CFG_DATA_W      = 7;

    localparam logic [1:0] DEGREE_RESET      = 2'd3;
    localparam logic [6:0] POINT_COUNT_RESET = 7'd4;

    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 36;

    typedef struct packed {
        logic [1:0]         op;
        logic [6:0]         index;
        logic signed [31:0] knot_value;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [23:0]        weight;
        logic signed [31:0] param_u;
    } item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [5:0]         span_found;
    } result_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7fff_ffff;
        end else if (v < -66'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

@@ hw/rtl/nurbs_curve_point_eval.sv @@
// top level of the rational b-spline curve point evaluator
// depends on nce_pkg, nce_core and nce_div
//
// usage:
//   input channel s_*: one transaction per operation (load knot, load control
//   point with weight, evaluate). output channel m_*: exactly one result
//   transaction per input transaction, in order.
//   configuration: cfg_wr_en/cfg_index/cfg_wr_data write degree (index 0) or
//   point_count (index 1), one register per write; write only while the block is idle.
// processing:
//   one transaction is worked at a time; s_ready is low while it runs.
//   loads and refused evaluations go straight to the result. an evaluation
//   reads the domain ends, runs the span search (skipped when u sits at the
//   top of the domain), the cox-de boor basis with one divide per nonzero basis
//   denominator (degree*(degree+1)/2 terms in all) and the weighted sums, then
//   divides by the weight sum; a zero weight sum skips these final divides.
//   evaluation time is set by the shared divider, which retires one quotient
//   bit per cycle, and by the knot store read during the search.
// reset: aresetn is synchronous, active low; degree returns to 3, point_count
//   to 4, both channels go idle. knot and point stores are not cleared.
// stall: the result sits in the output register while m_ready is low; the
//   next transaction is accepted and worked, and waits in the core until the
//   output register frees.
module nurbs_curve_point_eval (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [0:0]                          cfg_index,
    input  logic [nce_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    // input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_op,
    input  logic [6:0]                          s_index,
    input  logic signed [31:0]                  s_knot_value,
    input  logic signed [31:0]                  s_coord_x,
    input  logic signed [31:0]                  s_coord_y,
    input  logic signed [31:0]                  s_coord_z,
    input  logic [23:0]                         s_weight,
    input  logic signed [31:0]                  s_param_u,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [2:0]                          m_status,
    output logic signed [31:0]                  m_point_x,
    output logic signed [31:0]                  m_point_y,
    output logic signed [31:0]                  m_point_z,
    output logic [5:0]                          m_span_found
);
    logic [1:0]        degree_reg;
    logic [6:0]        point_count_reg;
    logic              m_valid_reg;
    nce_pkg::result_t  m_data_reg;

    nce_pkg::item_t    item;
    nce_pkg::result_t  core_res;
    logic              core_res_valid;
    logic              core_res_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg      <= nce_pkg::DEGREE_RESET;
            point_count_reg <= nce_pkg::POINT_COUNT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                nce_pkg::REG_DEGREE:      degree_reg      <= cfg_wr_data[1:0];
                nce_pkg::REG_POINT_COUNT: point_count_reg <= cfg_wr_data[6:0];
                default: ;
            endcase
        end
    end

    // pack the input transaction
    always_comb begin
        item.op         = s_op;
        item.index      = s_index;
        item.knot_value = s_knot_value;
        item.coord_x    = s_coord_x;
        item.coord_y    = s_coord_y;
        item.coord_z    = s_coord_z;
        item.weight     = s_weight;
        item.param_u    = s_param_u;
    end

    nce_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_item     (item),
        .degree      (degree_reg),
        .point_count (point_count_reg),
        .res_valid   (core_res_valid),
        .res_ready   (core_res_ready),
        .res         (core_res)
    );

    // output register, refilled the cycle it is drained
    assign core_res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (core_res_ready) begin
            m_valid_reg <= core_res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_res_ready && core_res_valid) begin
            m_data_reg <= core_res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_data_reg.status;
    assign m_point_x    = m_data_reg.point_x;
    assign m_point_y    = m_data_reg.point_y;
    assign m_point_z    = m_data_reg.point_z;
    assign m_span_found = m_data_reg.span_found;

endmodule

@@ hw/rtl/nce_div.sv @@
// shared signed divider, restoring, one quotient bit per cycle, truncating
// depends on nce_pkg for widths
module nce_div (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic signed [nce_pkg::DIV_NUM_W-1:0]   num,
    input  logic signed [nce_pkg::DIV_DEN_W-1:0]   den,
    output logic                                   done,
    output logic signed [nce_pkg::DIV_NUM_W-1:0]   quo
);
    localparam int NW    = nce_pkg::DIV_NUM_W;
    localparam int DW    = nce_pkg::DIV_DEN_W;
    localparam int CNT_W = $clog2(NW);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NW-1:0]    dvd_reg;
    logic [DW-1:0]    rem_reg;
    logic [NW-1:0]    quo_reg;
    logic [DW-1:0]    dmag_reg;
    logic             neg_reg;

    logic [DW:0]      rem_sh;
    logic             bit_q;
    logic [DW:0]      rem_new;
    logic [NW-1:0]    q_final;

    always_comb begin
        rem_sh  = {rem_reg, dvd_reg[NW-1]};
        bit_q   = (rem_sh >= {1'b0, dmag_reg});
        rem_new = bit_q ? (rem_sh - {1'b0, dmag_reg}) : rem_sh;
        q_final = {quo_reg[NW-2:0], bit_q};
        done    = busy_reg && (cnt_reg == CNT_W'(NW - 1));
        quo     = neg_reg ? -$signed(q_final) : $signed(q_final);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (done) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg  <= '0;
            dvd_reg  <= num[NW-1] ? NW'(-num) : NW'(num);
            dmag_reg <= den[DW-1] ? DW'(-den) : DW'(den);
            neg_reg  <= num[NW-1] ^ den[DW-1];
            rem_reg  <= '0;
            quo_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            dvd_reg <= {dvd_reg[NW-2:0], 1'b0};
            rem_reg <= rem_new[DW-1:0];
            quo_reg <= q_final;
        end
    end

endmodule

@@ hw/rtl/nce_core.sv @@
// sequencer, local stores and shared multiplier of the curve evaluator
// depends on nce_pkg and nce_div
module nce_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  nce_pkg::item_t      in_item,
    input  logic [1:0]          degree,
    input  logic [6:0]          point_count,
    output logic                res_valid,
    input  logic                res_ready,
    output nce_pkg::result_t    res
);
    localparam int MAX_DEGREE = nce_pkg::MAX_DEGREE;
    localparam int MAX_POINTS = nce_pkg::MAX_POINTS;
    localparam int KD   = MAX_POINTS + MAX_DEGREE + 1;
    localparam int KA_W = $clog2(KD);
    localparam int PA_W = $clog2(MAX_POINTS);
    localparam int DG_W = $clog2(MAX_DEGREE + 1);
    localparam int CW   = KA_W + 8;
    localparam logic [1:0] LAST_COORD = 2'd2;

    nce_pkg::state_t state_reg, state_next;

    logic signed [31:0] knot_mem [0:KD-1];
    logic signed [31:0] px_mem [0:MAX_POINTS-1];
    logic signed [31:0] py_mem [0:MAX_POINTS-1];
    logic signed [31:0] pz_mem [0:MAX_POINTS-1];
    logic [23:0]        pw_mem [0:MAX_POINTS-1];

    logic signed [31:0] kdata_reg;
    logic signed [31:0] px_rd_reg, py_rd_reg, pz_rd_reg;
    logic [23:0]        pw_rd_reg;

    logic signed [31:0] u_reg, lo_reg, saved_reg;
    logic [KA_W-1:0]    span_reg, k_reg;
    logic [DG_W-1:0]    i_reg, j_reg, r_reg;
    logic [1:0]         c_reg;
    logic signed [31:0] nb_reg [0:MAX_DEGREE];
    logic signed [31:0] lf_reg [0:MAX_DEGREE];
    logic signed [31:0] rt_reg [0:MAX_DEGREE];
    logic signed [nce_pkg::DIV_DEN_W-1:0] d_reg;
    logic signed [65:0] prod_reg;
    logic signed [32:0] wn_reg;
    logic signed [63:0] nx_reg, ny_reg, nz_reg;
    logic signed [31:0] den_reg;
    nce_pkg::result_t   res_reg;

    logic [CW-1:0]      p_cw, n_cw, idx_cw;
    logic [KA_W-1:0]    p_a, n_a, kaddr, pt_addr;
    logic [PA_W-1:0]    pt_idx;
    logic [DG_W-1:0]    p_d;
    logic               cfg_bad, accept, knot_we, point_we;
    nce_pkg::status_t   acc_sts;
    logic signed [31:0] u1, u2;
    logic               at_top, bas_last, bas_zero;
    nce_pkg::state_t    after_span;
    logic signed [nce_pkg::DIV_DEN_W-1:0] d_sum;
    logic signed [32:0] mul_a, mul_b, wn_c;
    logic               div_start, div_done;
    logic signed [nce_pkg::DIV_NUM_W-1:0] div_num, div_quo;
    logic signed [nce_pkg::DIV_DEN_W-1:0] div_den;
    logic signed [31:0] nb_upd, saved_upd;

    // configuration view, widened for compares
    always_comb begin
        p_cw    = CW'(degree);
        n_cw    = CW'(point_count);
        idx_cw  = CW'(in_item.index);
        p_a     = p_cw[KA_W-1:0];
        n_a     = n_cw[KA_W-1:0];
        p_d     = p_cw[DG_W-1:0];
        cfg_bad = (p_cw > CW'(MAX_DEGREE)) || (n_cw > CW'(MAX_POINTS)) || (n_cw < p_cw + 1'b1);
        accept  = in_valid && in_ready;
        knot_we = accept && (in_item.op == nce_pkg::OP_LOAD_KNOT) && (idx_cw < CW'(KD));
        point_we = accept && (in_item.op == nce_pkg::OP_LOAD_POINT)
                   && (idx_cw < CW'(MAX_POINTS)) && (in_item.weight != '0);
    end

    // status of the incoming transaction
    always_comb begin
        acc_sts = nce_pkg::STS_OK;
        case (in_item.op)
            nce_pkg::OP_LOAD_KNOT: begin
                if (idx_cw >= CW'(KD)) begin
                    acc_sts = nce_pkg::STS_INDEX_REJ;
                end
            end
            nce_pkg::OP_LOAD_POINT: begin
                if (idx_cw >= CW'(MAX_POINTS)) begin
                    acc_sts = nce_pkg::STS_INDEX_REJ;
                end else if (in_item.weight == '0) begin
                    acc_sts = nce_pkg::STS_WEIGHT_REJ;
                end
            end
            nce_pkg::OP_EVAL: begin
                if (cfg_bad) begin
                    acc_sts = nce_pkg::STS_BAD_CFG;
                end
            end
            default: ;
        endcase
    end

    // domain clamp and span bookkeeping
    always_comb begin
        u1         = (u_reg < lo_reg) ? lo_reg : u_reg;
        u2         = (u1 > kdata_reg) ? kdata_reg : u1;
        at_top     = (u2 >= kdata_reg);
        after_span = (p_d == '0) ? nce_pkg::S_WA : nce_pkg::S_LRA;
    end

    // cox-de boor term
    always_comb begin
        d_sum    = nce_pkg::DIV_DEN_W'(rt_reg[r_reg + 1'b1])
                 + nce_pkg::DIV_DEN_W'(lf_reg[j_reg - r_reg]);
        bas_zero = (d_sum == '0);
        bas_last = ((DG_W+1)'(r_reg) + 1'b1 == (DG_W+1)'(j_reg)) && (j_reg == p_d);
        if (state_reg == nce_pkg::S_BAS) begin
            nb_upd    = saved_reg;
            saved_upd = '0;
        end else begin
            nb_upd    = nce_pkg::sat32(66'(saved_reg) + 66'(div_quo));
            saved_upd = nce_pkg::sat32(66'(nb_reg[r_reg]) - 66'(div_quo));
        end
    end

    // store addresses
    always_comb begin
        unique case (state_reg)
            nce_pkg::S_IDLE: kaddr = p_a;
            nce_pkg::S_LO:   kaddr = n_a;
            nce_pkg::S_HI:   kaddr = p_a + 1'b1;
            nce_pkg::S_SRCH: kaddr = k_reg + 1'b1;
            nce_pkg::S_LRL:  kaddr = span_reg + KA_W'(j_reg);
            nce_pkg::S_LRR:  kaddr = span_reg - KA_W'(j_reg);
            default:         kaddr = span_reg;
        endcase
        if (state_reg == nce_pkg::S_FIN || state_reg == nce_pkg::S_DEG) begin
            pt_addr = span_reg;
        end else begin
            pt_addr = span_reg - p_a + KA_W'(i_reg);
        end
        pt_idx = pt_addr[PA_W-1:0];
    end

    // shared multiplier operands
    always_comb begin
        wn_c = prod_reg[62:30];
        unique case (state_reg)
            nce_pkg::S_BAS: begin
                mul_a = 33'(nb_reg[r_reg]);
                mul_b = 33'(rt_reg[r_reg + 1'b1]);
            end
            nce_pkg::S_WN: begin
                mul_a = $signed({9'b0, pw_rd_reg});
                mul_b = 33'(nb_reg[i_reg]);
            end
            nce_pkg::S_WX: begin
                mul_a = 33'(px_rd_reg);
                mul_b = wn_c;
            end
            nce_pkg::S_WY: begin
                mul_a = 33'(py_rd_reg);
                mul_b = wn_reg;
            end
            nce_pkg::S_WZ: begin
                mul_a = 33'(pz_rd_reg);
                mul_b = wn_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // shared divider operands
    always_comb begin
        div_den = nce_pkg::DIV_DEN_W'(den_reg);
        unique case (state_reg)
            nce_pkg::S_BMUL: begin
                div_start = 1'b1;
                div_num   = prod_reg[63:0];
                div_den   = d_reg;
            end
            nce_pkg::S_FIN: begin
                div_start = (den_reg != '0);
                div_num   = nx_reg;
            end
            nce_pkg::S_DIV: begin
                div_start = div_done && (c_reg != LAST_COORD);
                div_num   = (c_reg == 2'd0) ? ny_reg : nz_reg;
            end
            default: begin
                div_start = 1'b0;
                div_num   = nx_reg;
            end
        endcase
    end

    nce_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nce_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        in_ready   = (state_reg == nce_pkg::S_IDLE);
        res_valid  = (state_reg == nce_pkg::S_DONE);
        unique case (state_reg)
            nce_pkg::S_IDLE: begin
                if (in_valid) begin
                    state_next = (in_item.op == nce_pkg::OP_EVAL && !cfg_bad)
                               ? nce_pkg::S_LO : nce_pkg::S_DONE;
                end
            end
            nce_pkg::S_LO: state_next = nce_pkg::S_HI;
            nce_pkg::S_HI: begin
                if (at_top || !(p_a + 1'b1 < n_a)) begin
                    state_next = after_span;
                end else begin
                    state_next = nce_pkg::S_SRCH;
                end
            end
            nce_pkg::S_SRCH: begin
                if (!(k_reg + 1'b1 < n_a)) begin
                    state_next = after_span;
                end
            end
            nce_pkg::S_LRA: state_next = nce_pkg::S_LRL;
            nce_pkg::S_LRL: state_next = nce_pkg::S_LRR;
            nce_pkg::S_LRR: begin
                state_next = (j_reg == p_d) ? nce_pkg::S_BAS : nce_pkg::S_LRL;
            end
            nce_pkg::S_BAS: begin
                if (bas_zero) begin
                    state_next = bas_last ? nce_pkg::S_WA : nce_pkg::S_BAS;
                end else begin
                    state_next = nce_pkg::S_BMUL;
                end
            end
            nce_pkg::S_BMUL: state_next = nce_pkg::S_BDIV;
            nce_pkg::S_BDIV: begin
                if (div_done) begin
                    state_next = bas_last ? nce_pkg::S_WA : nce_pkg::S_BAS;
                end
            end
            nce_pkg::S_WA: state_next = nce_pkg::S_WN;
            nce_pkg::S_WN: state_next = nce_pkg::S_WX;
            nce_pkg::S_WX: state_next = nce_pkg::S_WY;
            nce_pkg::S_WY: state_next = nce_pkg::S_WZ;
            nce_pkg::S_WZ: state_next = nce_pkg::S_WE;
            nce_pkg::S_WE: begin
                state_next = (i_reg == p_d) ? nce_pkg::S_FIN : nce_pkg::S_WA;
            end
            nce_pkg::S_FIN: begin
                state_next = (den_reg == '0) ? nce_pkg::S_DEG : nce_pkg::S_DIV;
            end
            nce_pkg::S_DEG: state_next = nce_pkg::S_DONE;
            nce_pkg::S_DIV: begin
                if (div_done && c_reg == LAST_COORD) begin
                    state_next = nce_pkg::S_DONE;
                end
            end
            nce_pkg::S_DONE: begin
                if (res_ready) begin
                    state_next = nce_pkg::S_IDLE;
                end
            end
            default: state_next = nce_pkg::S_IDLE;
        endcase
    end

    // local stores
    always_ff @(posedge aclk) begin
        if (knot_we) begin
            knot_mem[idx_cw[KA_W-1:0]] <= in_item.knot_value;
        end
        kdata_reg <= knot_mem[kaddr];
    end

    always_ff @(posedge aclk) begin
        if (point_we) begin
            px_mem[idx_cw[PA_W-1:0]] <= in_item.coord_x;
            py_mem[idx_cw[PA_W-1:0]] <= in_item.coord_y;
            pz_mem[idx_cw[PA_W-1:0]] <= in_item.coord_z;
            pw_mem[idx_cw[PA_W-1:0]] <= in_item.weight;
        end
        px_rd_reg <= px_mem[pt_idx];
        py_rd_reg <= py_mem[pt_idx];
        pz_rd_reg <= pz_mem[pt_idx];
        pw_rd_reg <= pw_mem[pt_idx];
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            nce_pkg::S_IDLE: begin
                if (in_valid) begin
                    u_reg     <= in_item.param_u;
                    res_reg   <= '{status: acc_sts, default: '0};
                    nb_reg[0] <= nce_pkg::ONE_Q30;
                    nx_reg    <= '0;
                    ny_reg    <= '0;
                    nz_reg    <= '0;
                    den_reg   <= '0;
                    i_reg     <= '0;
                end
            end
            nce_pkg::S_LO: lo_reg <= kdata_reg;
            nce_pkg::S_HI: begin
                u_reg    <= u2;
                span_reg <= at_top ? (n_a - 1'b1) : p_a;
                k_reg    <= p_a + 1'b1;
            end
            nce_pkg::S_SRCH: begin
                if (kdata_reg <= u_reg) begin
                    span_reg <= k_reg;
                end
                k_reg <= k_reg + 1'b1;
            end
            nce_pkg::S_LRA: j_reg <= DG_W'(1);
            nce_pkg::S_LRL: lf_reg[j_reg] <= nce_pkg::sat32(66'(u_reg) - 66'(kdata_reg));
            nce_pkg::S_LRR: begin
                rt_reg[j_reg] <= nce_pkg::sat32(66'(kdata_reg) - 66'(u_reg));
                if (j_reg == p_d) begin
                    j_reg     <= DG_W'(1);
                    r_reg     <= '0;
                    saved_reg <= '0;
                end else begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            nce_pkg::S_BAS, nce_pkg::S_BDIV: begin
                if (state_reg == nce_pkg::S_BAS) begin
                    d_reg <= d_sum;
                end
                if ((state_reg == nce_pkg::S_BAS && bas_zero)
                    || (state_reg == nce_pkg::S_BDIV && div_done)) begin
                    nb_reg[r_reg] <= nb_upd;
                    if ((DG_W+1)'(r_reg) + 1'b1 == (DG_W+1)'(j_reg)) begin
                        nb_reg[j_reg] <= saved_upd;
                        j_reg         <= j_reg + 1'b1;
                        r_reg         <= '0;
                        saved_reg     <= '0;
                    end else begin
                        r_reg     <= r_reg + 1'b1;
                        saved_reg <= saved_upd;
                    end
                end
            end
            nce_pkg::S_WX: begin
                wn_reg  <= wn_c;
                den_reg <= den_reg + 32'(wn_c);
            end
            nce_pkg::S_WY: nx_reg <= nx_reg + prod_reg[63:0];
            nce_pkg::S_WZ: ny_reg <= ny_reg + prod_reg[63:0];
            nce_pkg::S_WE: begin
                nz_reg <= nz_reg + prod_reg[63:0];
                i_reg  <= i_reg + 1'b1;
            end
            nce_pkg::S_FIN: begin
                res_reg.span_found <= 6'(span_reg);
                c_reg              <= '0;
            end
            nce_pkg::S_DEG: begin
                res_reg.status  <= nce_pkg::STS_DEGEN;
                res_reg.point_x <= px_rd_reg;
                res_reg.point_y <= py_rd_reg;
                res_reg.point_z <= pz_rd_reg;
            end
            nce_pkg::S_DIV: begin
                if (div_done) begin
                    case (c_reg)
                        2'd0:    res_reg.point_x <= nce_pkg::sat32(66'(div_quo));
                        2'd1:    res_reg.point_y <= nce_pkg::sat32(66'(div_quo));
                        default: res_reg.point_z <= nce_pkg::sat32(66'(div_quo));
                    endcase
                    c_reg <= c_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign res = res_reg;

`ifndef ASSERT_OFF
    a_span_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == nce_pkg::S_WA) |-> (span_reg >= p_a) && (span_reg < n_a))
        else $error("span outside [degree, point_count-1]");

    a_div_done_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == nce_pkg::S_BDIV) || (state_reg == nce_pkg::S_DIV))
        else $error("divider finished outside a divide state");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg != nce_pkg::S_IDLE))
        else $error("accepted transaction did not start");

    a_no_zero_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == nce_pkg::S_DIV && div_start) |-> (den_reg != '0))
        else $error("final divide started with zero weight sum");
`endif

endmodule

@@ sim/nurbs_curve_point_eval_test.sv @@
// self-checking testbench of the nurbs curve point evaluator: loads, evaluations, configurations
// depends on nce_pkg and nurbs_curve_point_eval; holds its own fixed-point curve predictor
`timescale 1ns / 1ps

module nurbs_curve_point_eval_test;

    localparam int  KNOT_SLOTS  = 68;
    localparam int  POINT_SLOTS = 64;
    localparam longint CYCLE_LIMIT = 6000000;
    localparam longint Q30_ONE  = 64'sd1073741824;
    localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [nce_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op = '0;
    logic [6:0]  s_index = '0;
    logic signed [31:0] s_knot_value = '0;
    logic signed [31:0] s_coord_x = '0;
    logic signed [31:0] s_coord_y = '0;
    logic signed [31:0] s_coord_z = '0;
    logic [23:0] s_weight = '0;
    logic signed [31:0] s_param_u = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic signed [31:0] m_point_x;
    logic signed [31:0] m_point_y;
    logic signed [31:0] m_point_z;
    logic [5:0]  m_span_found;

    nurbs_curve_point_eval uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_index(s_index),
        .s_knot_value(s_knot_value), .s_coord_x(s_coord_x), .s_coord_y(s_coord_y),
        .s_coord_z(s_coord_z), .s_weight(s_weight), .s_param_u(s_param_u),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_point_x(m_point_x), .m_point_y(m_point_y), .m_point_z(m_point_z),
        .m_span_found(m_span_found)
    );

    always #5 aclk = ~aclk;

    // shadow of the block state used by the predictor
    longint      knot_mem [KNOT_SLOTS];
    longint      px_mem [POINT_SLOTS];
    longint      py_mem [POINT_SLOTS];
    longint      pz_mem [POINT_SLOTS];
    longint      wt_mem [POINT_SLOTS];
    int          cur_degree;
    int          cur_count;

    nce_pkg::result_t expected_points [$];
    int          mismatch_count = 0;
    int          checked_count = 0;
    int          eval_count = 0;
    int          degen_count = 0;
    longint      cycle_count = 0;
    bit          quiet = 1'b0;   // no idling on either side while set

    // saturate to signed 32 bits
    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // one evaluation: refuse bad settings, clamp u, find span, cox-de boor basis, rational weighted mean
    function automatic nce_pkg::result_t curve_point(input logic signed [31:0] u_in);
        nce_pkg::result_t res;
        longint u, lo, hi, saved, d, q, old, wn, nx, ny, nz, den;
        longint nb [4];
        longint lf [4];
        longint rt [4];
        int span, k;
        res = '0;
        nx = 0; ny = 0; nz = 0; den = 0;
        if (cur_degree > 3 || cur_count > POINT_SLOTS || cur_count < cur_degree + 1) begin
            res.status = nce_pkg::STS_BAD_CFG;
            return res;
        end
        u  = longint'(u_in);
        lo = knot_mem[cur_degree];
        hi = knot_mem[cur_count];
        if (u < lo) u = lo;
        if (u > hi) u = hi;
        // span search, top of domain goes to last span
        if (u >= hi) begin
            span = cur_count - 1;
        end else begin
            span = cur_degree;
            for (int i = cur_degree + 1; i < cur_count; i++) begin
                if (knot_mem[i] <= u) span = i;
            end
        end
        nb[0] = Q30_ONE;
        for (int j = 1; j <= cur_degree; j++) begin
            saved = 0;
            lf[j] = clamp32(u - knot_mem[span + 1 - j]);
            rt[j] = clamp32(knot_mem[span + j] - u);
            for (int r = 0; r < j; r++) begin
                d = rt[r + 1] + lf[j - r];
                if (d == 0) begin
                    // zero denominator skips the term
                    nb[r] = saved;
                    saved = 0;
                end else begin
                    old   = nb[r];
                    q     = (old * rt[r + 1]) / d;
                    nb[r] = clamp32(saved + q);
                    saved = clamp32(old - q);
                end
            end
            nb[j] = saved;
        end
        for (int i = 0; i <= cur_degree; i++) begin
            k   = span - cur_degree + i;
            wn  = (wt_mem[k] * nb[i]) >>> 30;   // floor
            nx += px_mem[k] * wn;
            ny += py_mem[k] * wn;
            nz += pz_mem[k] * wn;
            den += wn;
        end
        res.span_found = span[5:0];
        if (den == 0) begin
            res.status  = nce_pkg::STS_DEGEN;
            res.point_x = px_mem[span][31:0];
            res.point_y = py_mem[span][31:0];
            res.point_z = pz_mem[span][31:0];
        end else begin
            res.status  = nce_pkg::STS_OK;
            res.point_x = 32'(clamp32(nx / den));
            res.point_y = 32'(clamp32(ny / den));
            res.point_z = 32'(clamp32(nz / den));
        end
        return res;
    endfunction

    // expected result of one accepted transaction, updating the shadow stores
    function automatic nce_pkg::result_t predict_result(input nce_pkg::item_t it);
        nce_pkg::result_t res;
        res = '0;
        case (nce_pkg::op_t'(it.op))
            nce_pkg::OP_LOAD_KNOT: begin
                if (it.index >= KNOT_SLOTS) res.status = nce_pkg::STS_INDEX_REJ;
                else knot_mem[it.index] = longint'(it.knot_value);
            end
            nce_pkg::OP_LOAD_POINT: begin
                if (it.index >= POINT_SLOTS) begin
                    res.status = nce_pkg::STS_INDEX_REJ;
                end else if (it.weight == 0) begin
                    res.status = nce_pkg::STS_WEIGHT_REJ;
                end else begin
                    px_mem[it.index] = longint'(it.coord_x);
                    py_mem[it.index] = longint'(it.coord_y);
                    pz_mem[it.index] = longint'(it.coord_z);
                    wt_mem[it.index] = longint'({40'd0, it.weight});
                end
            end
            nce_pkg::OP_EVAL: begin
                res = curve_point(it.param_u);
                eval_count++;
                if (res.status == nce_pkg::STS_DEGEN) degen_count++;
            end
            default: ;
        endcase
        return res;
    endfunction

    // send one transaction, sometimes after a random gap (never while quiet); returns at the accepting edge
    task automatic send_item(input nce_pkg::item_t it);
        bit rdy;
        if (!quiet && $urandom_range(99) < 34) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= it.op;
        s_index      <= it.index;
        s_knot_value <= it.knot_value;
        s_coord_x    <= it.coord_x;
        s_coord_y    <= it.coord_y;
        s_coord_z    <= it.coord_z;
        s_weight     <= it.weight;
        s_param_u    <= it.param_u;
        do begin
            @(negedge aclk);
            rdy = s_ready;
            @(posedge aclk);
        end while (!rdy);
        expected_points.push_back(predict_result(it));
    endtask

    task automatic send_knot(input int idx, input logic signed [31:0] val);
        nce_pkg::item_t it;
        it = nce_pkg::item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        it.op = nce_pkg::OP_LOAD_KNOT;
        it.index = idx[6:0];
        it.knot_value = val;
        send_item(it);
    endtask

    task automatic send_point(input int idx, input logic signed [31:0] x,
                              input logic signed [31:0] y, input logic signed [31:0] z,
                              input logic [23:0] w);
        nce_pkg::item_t it;
        it = nce_pkg::item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        it.op = nce_pkg::OP_LOAD_POINT;
        it.index = idx[6:0];
        it.coord_x = x; it.coord_y = y; it.coord_z = z;
        it.weight = w;
        send_item(it);
    endtask

    task automatic send_eval(input logic signed [31:0] u);
        nce_pkg::item_t it;
        it = nce_pkg::item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        it.op = nce_pkg::OP_EVAL;
        it.param_u = u;
        send_item(it);
    endtask

    // stop sending and wait until every expected result has arrived
    task automatic drain;
        s_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // register write, only from an idle block
    task automatic write_config(input int degree_val, input int count_val);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= nce_pkg::REG_DEGREE;
        cfg_wr_data <= nce_pkg::CFG_DATA_W'(degree_val);
        @(posedge aclk);
        cfg_index   <= nce_pkg::REG_POINT_COUNT;
        cfg_wr_data <= nce_pkg::CFG_DATA_W'(count_val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
        cur_degree = degree_val & 3;
        cur_count  = count_val & 127;
    endtask

    // clamped, nondecreasing knot vector with occasional repeated knots
    task automatic load_clamped_knots(input int step_max);
        longint v;
        v = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
        for (int i = 0; i <= cur_count + cur_degree; i++) begin
            if (i > cur_degree && i <= cur_count && $urandom_range(9) != 0)
                v += $urandom_range(1, step_max);
            send_knot(i, v[31:0]);
        end
    endtask

    // every store entry gets written so that no evaluation reads an unwritten one
    task automatic test_preload;
        for (int i = 0; i < KNOT_SLOTS; i++) send_knot(i, ONE_Q16 * (i - 3));
        for (int i = 0; i < POINT_SLOTS; i++)
            send_point(i, $urandom, $urandom, $urandom, 24'($urandom_range(1, 24'hff_ffff)));
    endtask

    // index and weight checks, unused op, field extremes
    task automatic test_load_checks;
        nce_pkg::item_t it;
        send_knot(KNOT_SLOTS - 1, 32'sh7fff_ffff);
        send_knot(KNOT_SLOTS - 1, 32'sh8000_0000);
        send_knot(KNOT_SLOTS, 32'sh1234_5678);
        send_knot(127, 32'sh7fff_ffff);
        send_point(POINT_SLOTS, 32'sh7fff_ffff, 32'sh8000_0000, 0, 24'd0);  // index before weight
        send_point(127, 0, 0, 0, 24'hff_ffff);
        send_point(5, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 24'd0);
        send_point(POINT_SLOTS - 1, 32'sh8000_0000, 32'sh7fff_ffff, -1, 24'hff_ffff);
        it = nce_pkg::item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        it.op = nce_pkg::OP_NONE;
        send_item(it);
    endtask

    // degree 3, four points, unit domain: clamps, top span, degenerate sum, inverted domain; degrees 0, 1
    task automatic test_eval_cases;
        write_config(3, 4);
        for (int i = 0; i < 8; i++) send_knot(i, (i < 4) ? 32'sd0 : ONE_Q16);
        for (int i = 0; i < 4; i++)
            send_point(i, ONE_Q16 * i, -ONE_Q16 * i, 32'sh7fff_0000, 24'h01_0000);
        send_eval(32'sh8000_0000);          // below domain
        send_eval(32'sh7fff_ffff);          // above domain
        send_eval(ONE_Q16);                 // exactly at top end
        send_eval(32'sh0000_8000);
        for (int i = 0; i < 4; i++) send_point(i, $urandom, $urandom, $urandom, 24'd1);
        send_eval(32'sh0000_8000);          // all weighted basis values floor to zero
        send_knot(3, 32'sh0002_0000);       // inverted domain
        send_eval(32'sh0000_4000);
        send_knot(3, 0);
        write_config(0, 1);                 // degree zero, single point
        send_eval($urandom);
        write_config(1, 2);
        send_eval(32'sh0000_c000);
    endtask

    // evaluation refused for impossible settings
    task automatic test_bad_config;
        write_config(3, 3);
        send_eval($urandom);
        write_config(0, 0);
        send_eval($urandom);
        write_config(2, 65);
        send_eval($urandom);
        write_config(3, 127);
        send_eval($urandom);
    endtask

    // well-formed curves with random content, plus some noise transactions
    task automatic test_random_curves;
        int degree_val, count_val, n_items, pick;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin degree_val = 3; count_val = 64; end
                1: begin degree_val = 0; count_val = 1; end
                2: begin degree_val = 3; count_val = 4; end
                default: begin
                    degree_val = $urandom_range(0, 3);
                    count_val  = $urandom_range(degree_val + 1, 16);
                end
            endcase
            quiet = (phase == 4);
            write_config(degree_val, count_val);
            load_clamped_knots((phase == 5) ? 32'h7fff_ffff / 80 : (1 << 17));
            for (int i = 0; i < count_val; i++)
                send_point(i, $urandom, $urandom, $urandom,
                           24'(($urandom_range(3) == 0) ? $urandom_range(1, 255) : $urandom));
            n_items = (phase == 0) ? 40 : 110;
            for (int i = 0; i < n_items; i++) begin
                pick = $urandom_range(99);
                if (pick < 55) begin
                    send_eval(32'(($urandom_range(9) == 0) ? longint'($urandom)
                              : (knot_mem[cur_degree] + $urandom_range(0, 1 << 22) - (1 << 20))));
                end else if (pick < 80) begin
                    send_point($urandom_range(0, count_val - 1), $urandom, $urandom, $urandom,
                               24'(($urandom_range(9) == 0) ? 0 : $urandom));
                end else if (pick < 88) begin
                    send_point($urandom_range(POINT_SLOTS, 127), $urandom, $urandom, $urandom,
                               24'($urandom));
                end else if (pick < 95) begin
                    send_knot($urandom_range(KNOT_SLOTS, 127), $urandom);
                end else begin
                    send_knot($urandom_range(0, count_val + degree_val), $urandom);
                end
                // sender holds off until the pipe is empty
                if (phase == 3 && i == 50) drain();
            end
        end
        quiet = 1'b0;
    endtask

    // result side: random stalls, then compare at the accepting edge
    bit               out_fire;
    nce_pkg::result_t out_seen;

    always @(posedge aclk) begin
        if (aresetn) m_ready <= quiet || ($urandom_range(99) >= 34);
    end

    always @(negedge aclk) begin
        out_fire = aresetn && m_valid && m_ready;
        out_seen = '{m_status, m_point_x, m_point_y, m_point_z, m_span_found};
    end

    always @(posedge aclk) begin
        nce_pkg::result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_points.size());
            $display("nurbs_curve_point_eval_test: FAIL");
            $finish;
        end
        if (out_fire) begin
            checked_count++;
            if (expected_points.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transaction status=%0d", out_seen.status);
            end else begin
                want = expected_points.pop_front();
                if (want.status !== out_seen.status || want.point_x !== out_seen.point_x ||
                    want.point_y !== out_seen.point_y || want.point_z !== out_seen.point_z ||
                    want.span_found !== out_seen.span_found) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch #%0d: exp sts=%0d x=%h y=%h z=%h span=%0d",
                                 checked_count, want.status, want.point_x, want.point_y,
                                 want.point_z, want.span_found);
                        $display("    got sts=%0d x=%h y=%h z=%h span=%0d",
                                 out_seen.status, out_seen.point_x, out_seen.point_y,
                                 out_seen.point_z, out_seen.span_found);
                    end
                end
            end
        end
    end

    initial begin
        cur_degree = nce_pkg::DEGREE_RESET;
        cur_count  = nce_pkg::POINT_COUNT_RESET;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_preload();
        test_load_checks();
        test_eval_cases();
        test_bad_config();
        test_random_curves();
        drain();
        repeat (50) @(posedge aclk);
        $display("covered %0d result transactions, %0d evaluations (%0d degenerate)",
                 checked_count, eval_count, degen_count);
        $display("over degrees 0..3, point counts 1..64 and refused settings");
        if (mismatch_count == 0 && expected_points.size() == 0) begin
            $display("nurbs_curve_point_eval_test: PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     expected_points.size());
            $display("nurbs_curve_point_eval_test: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/nce_pkg.sv
hw/rtl/nce_div.sv
hw/rtl/nce_core.sv
hw/rtl/nurbs_curve_point_eval.sv
sim/nurbs_curve_point_eval_test.sv
